/* rtl/i2cm_pkg.sv */
// i2cm_pkg: shared types and constants for the i2c master bit sequencer
// used by i2cm_front, i2cm_queue, i2cm_back and the top level
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

  localparam int BYTE_BITS = 8;
  localparam int BIT_W     = $clog2(BYTE_BITS);
  localparam int SUB_W     = 2;

  localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(BYTE_BITS - 1);

  localparam logic [2:0] OP_START = 3'd0;
  localparam logic [2:0] OP_STOP  = 3'd1;
  localparam logic [2:0] OP_WRITE = 3'd2;
  localparam logic [2:0] OP_READ  = 3'd3;
  localparam logic [2:0] OP_SACK  = 3'd4;
  localparam logic [2:0] OP_RACK  = 3'd5;

  typedef struct packed {
    logic [2:0]           op;
    logic [BYTE_BITS-1:0] data;
    logic                 scl_prev;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/i2c_master_bit_sequencer.sv */
// i2c_master_bit_sequencer: top level, front end, command queue and phase back end
// depends on i2cm_pkg, i2cm_front, i2cm_queue, i2cm_back
//
// Each accepted command beat becomes a run of output beats, one per pin phase:
// start 4, stop 3, write 24, read 17, send ack 3, receive ack 3; opcodes 6 and 7
// are accepted and produce nothing. The back end emits one phase per cycle while
// a command is queued and out_ready is high, and its phase and bit counters step
// through the phases of the head command. A two-entry command queue lets the input
// side accept further commands while earlier ones are still playing out, and the
// first phase of a command reports the scl level left by the one before it.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_bit_sequencer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  opcode,
  input  wire logic [7:0]  write_data,
  input  wire logic        ack_out,
  input  wire logic [7:0]  slave_bits,
  input  wire logic        slave_ack,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             scl_level,
  output logic             sda_level,
  output logic [7:0]       read_byte,
  output logic             ack_seen,
  output logic             last_phase
);

  logic           push;
  i2cm_pkg::cmd_t push_cmd;
  logic           q_full;
  logic           pop;
  logic           head_valid;
  i2cm_pkg::cmd_t head_cmd;

  i2cm_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .write_data (write_data),
    .ack_out    (ack_out),
    .slave_bits (slave_bits),
    .slave_ack  (slave_ack),
    .push       (push),
    .push_cmd   (push_cmd),
    .q_full     (q_full)
  );

  i2cm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  i2cm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .scl_level  (scl_level),
    .sda_level  (sda_level),
    .read_byte  (read_byte),
    .ack_seen   (ack_seen),
    .last_phase (last_phase)
  );

  // result fields stay clear away from the final phase
  a_fields_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_phase |-> (read_byte == 8'd0) && !ack_seen)
    else $error("read_byte or ack_seen set before final phase");

  // only a stop ends with scl high, and it leaves sda released
  a_last_high: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_phase && scl_level |-> sda_level)
    else $error("command ended with scl high and sda low");

  // nothing comes out in the cycle after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("output beat right after reset");

endmodule

`default_nettype wire

/* rtl/i2cm_front.sv */
// i2cm_front: takes command beats, drops unknown opcodes, packs queue entries
// tracks the scl level left behind by each command; depends on i2cm_pkg
`timescale 1ns / 1ps
`default_nettype none

module i2cm_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [2:0]                    opcode,
  input  wire logic [i2cm_pkg::BYTE_BITS-1:0] write_data,
  input  wire logic                          ack_out,
  input  wire logic [i2cm_pkg::BYTE_BITS-1:0] slave_bits,
  input  wire logic                          slave_ack,
  output logic                               push,
  output i2cm_pkg::cmd_t                     push_cmd,
  input  wire logic                          q_full
);

  logic scl_now;
  logic scl_now_next;
  logic known;
  logic take;

  assign in_ready = !q_full;
  assign take     = in_valid && in_ready;

  always_comb begin
    known         = 1'b1;
    push_cmd.op   = opcode;
    push_cmd.data = '0;
    push_cmd.scl_prev = scl_now;
    scl_now_next  = 1'b0;
    case (opcode)
      i2cm_pkg::OP_START: ;
      i2cm_pkg::OP_STOP:  scl_now_next = 1'b1;
      i2cm_pkg::OP_WRITE: push_cmd.data = write_data;
      i2cm_pkg::OP_READ:  push_cmd.data = slave_bits;
      i2cm_pkg::OP_SACK:  push_cmd.data = {{(i2cm_pkg::BYTE_BITS-1){1'b0}}, ack_out};
      i2cm_pkg::OP_RACK:  push_cmd.data = {{(i2cm_pkg::BYTE_BITS-1){1'b0}}, slave_ack};
      default: begin
        known        = 1'b0;
        scl_now_next = scl_now;
      end
    endcase
  end

  assign push = take && known;

  always_ff @(posedge clk) begin
    if (rst) begin
      scl_now <= 1'b1;
    end else if (push) begin
      scl_now <= scl_now_next;
    end
  end

endmodule

`default_nettype wire

/* rtl/i2cm_queue.sv */
// i2cm_queue: two-entry command queue between front and back
// depends on i2cm_pkg for the entry type
`timescale 1ns / 1ps
`default_nettype none

module i2cm_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire i2cm_pkg::cmd_t push_cmd,
  output logic                full,
  input  wire logic           pop,
  output logic                head_valid,
  output i2cm_pkg::cmd_t      head_cmd
);

  i2cm_pkg::cmd_t slots [2];
  logic [1:0]     count;
  logic           wr_ptr;
  logic           rd_ptr;
  logic           do_pop;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head_cmd   = slots[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= 2'd0;
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/i2cm_back.sv */
// i2cm_back: steps through the pin phases of the queue head, one per beat
// holds the output register; depends on i2cm_pkg
`timescale 1ns / 1ps
`default_nettype none

module i2cm_back (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          head_valid,
  input  wire i2cm_pkg::cmd_t                head_cmd,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic                               scl_level,
  output logic                               sda_level,
  output logic [i2cm_pkg::BYTE_BITS-1:0]     read_byte,
  output logic                               ack_seen,
  output logic                               last_phase
);

  logic [i2cm_pkg::BIT_W-1:0] bitn;
  logic [i2cm_pkg::BIT_W-1:0] bitn_next;
  logic [i2cm_pkg::SUB_W-1:0] sub;
  logic [i2cm_pkg::SUB_W-1:0] sub_next;
  logic                       fire;
  logic                       last;
  logic                       cur_bit;
  logic                       scl_next;
  logic                       sda_next;
  logic [i2cm_pkg::BYTE_BITS-1:0] rbyte_next;
  logic                       ack_next;

  assign fire    = head_valid && (!out_valid || out_ready);
  assign pop     = fire && last;
  assign cur_bit = head_cmd.data[i2cm_pkg::LAST_BIT - bitn];

  always_comb begin
    last       = 1'b0;
    bitn_next  = bitn;
    sub_next   = sub + 2'd1;
    scl_next   = head_cmd.scl_prev;
    sda_next   = 1'b1;
    rbyte_next = '0;
    ack_next   = 1'b0;
    case (head_cmd.op)
      i2cm_pkg::OP_START: begin
        last     = (sub == 2'd3);
        scl_next = (sub == 2'd0) ? head_cmd.scl_prev : (sub != 2'd3);
        sda_next = (sub == 2'd0) || (sub == 2'd1);
      end
      i2cm_pkg::OP_STOP: begin
        last     = (sub == 2'd2);
        scl_next = (sub == 2'd0) ? head_cmd.scl_prev : 1'b1;
        sda_next = (sub == 2'd2);
      end
      i2cm_pkg::OP_WRITE: begin
        last     = (bitn == i2cm_pkg::LAST_BIT) && (sub == 2'd2);
        sda_next = cur_bit;
        if (sub == 2'd0) begin
          scl_next = (bitn == '0) ? head_cmd.scl_prev : 1'b0;
        end else begin
          scl_next = (sub == 2'd1);
        end
        if (sub == 2'd2) begin
          sub_next  = 2'd0;
          bitn_next = bitn + i2cm_pkg::BIT_W'(1);
        end
      end
      i2cm_pkg::OP_READ: begin
        last = (bitn == i2cm_pkg::LAST_BIT) && (sub == 2'd2);
        if (sub != 2'd0) begin
          scl_next = (sub == 2'd1);
          sda_next = cur_bit;
        end
        if (last) begin
          rbyte_next = head_cmd.data;
        end
        if (sub == 2'd2) begin
          sub_next  = 2'd1;
          bitn_next = bitn + i2cm_pkg::BIT_W'(1);
        end
      end
      i2cm_pkg::OP_SACK: begin
        last     = (sub == 2'd2);
        sda_next = head_cmd.data[0];
        if (sub != 2'd0) begin
          scl_next = (sub == 2'd1);
        end
      end
      i2cm_pkg::OP_RACK: begin
        last = (sub == 2'd2);
        if (sub != 2'd0) begin
          scl_next = (sub == 2'd1);
          sda_next = head_cmd.data[0];
        end
        ack_next = last && head_cmd.data[0];
      end
      default: begin
        last = 1'b1;
      end
    endcase
    if (last) begin
      sub_next  = '0;
      bitn_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bitn      <= '0;
      sub       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        bitn      <= bitn_next;
        sub       <= sub_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      scl_level  <= scl_next;
      sda_level  <= sda_next;
      read_byte  <= rbyte_next;
      ack_seen   <= ack_next;
      last_phase <= last;
    end
  end

endmodule

`default_nettype wire

/* tb/sv/tb_i2c_master_bit_sequencer.sv */
// tb_i2c_master_bit_sequencer: self-checking bench for the i2c master bit sequencer
// drives command beats with bursty gaps, predicts every pin phase and checks each output beat
// depends on i2cm_pkg and the i2c_master_bit_sequencer rtl
`timescale 1ns / 1ps

module tb_i2c_master_bit_sequencer;

  localparam logic [2:0] OP_SPARE_LO = 3'd6;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam int TARGET_CMDS  = 460;
  localparam int HOLD_AT      = 150;
  localparam int PAUSE_AT     = 300;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct {
    logic       scl;
    logic       sda;
    logic [7:0] rbyte;
    logic       ack;
    logic       last;
  } pin_phase_t;

  class pin_phase_board;
    logic       scl_drv;
    logic       sda_drv;
    pin_phase_t pending_phases[$];
    int         errors;
    int         cmds_seen;

    function new();
      scl_drv   = 1'b1;
      sda_drv   = 1'b1;
      errors    = 0;
      cmds_seen = 0;
    endfunction

    function void add_phase(logic bus, logic [7:0] rb, logic ack, logic last);
      pin_phase_t p;
      p.scl   = scl_drv;
      p.sda   = bus;
      p.rbyte = rb;
      p.ack   = ack;
      p.last  = last;
      pending_phases.push_back(p);
    endfunction

    function void drive_sda(logic v, logic last);
      sda_drv = v;
      add_phase(sda_drv, 8'h00, 1'b0, last);
    endfunction

    function void drive_scl(logic v, logic bus, logic [7:0] rb, logic ack, logic last);
      scl_drv = v;
      add_phase(bus, rb, ack, last);
    endfunction

    function void note_command(logic [2:0] op, logic [7:0] wd, logic ao,
                               logic [7:0] sbits, logic sa);
      logic       b;
      logic [7:0] acc;
      cmds_seen++;
      acc = 8'h00;
      case (op)
        i2cm_pkg::OP_START: begin
          drive_sda(1'b1, 1'b0);
          drive_scl(1'b1, sda_drv, 8'h00, 1'b0, 1'b0);
          drive_sda(1'b0, 1'b0);
          drive_scl(1'b0, sda_drv, 8'h00, 1'b0, 1'b1);
        end
        i2cm_pkg::OP_STOP: begin
          drive_sda(1'b0, 1'b0);
          drive_scl(1'b1, sda_drv, 8'h00, 1'b0, 1'b0);
          drive_sda(1'b1, 1'b1);
        end
        i2cm_pkg::OP_WRITE: begin
          for (int i = 0; i < i2cm_pkg::BYTE_BITS; i++) begin
            b = wd[i2cm_pkg::BYTE_BITS-1-i];
            drive_sda(b, 1'b0);
            drive_scl(1'b1, sda_drv, 8'h00, 1'b0, 1'b0);
            drive_scl(1'b0, sda_drv, 8'h00, 1'b0, i == i2cm_pkg::BYTE_BITS-1);
          end
        end
        i2cm_pkg::OP_READ: begin
          drive_sda(1'b1, 1'b0);
          for (int i = 0; i < i2cm_pkg::BYTE_BITS; i++) begin
            b = sbits[i2cm_pkg::BYTE_BITS-1-i];
            drive_scl(1'b1, b, 8'h00, 1'b0, 1'b0);
            acc[i2cm_pkg::BYTE_BITS-1-i] = b;
            if (i == i2cm_pkg::BYTE_BITS-1) drive_scl(1'b0, b, acc, 1'b0, 1'b1);
            else drive_scl(1'b0, b, 8'h00, 1'b0, 1'b0);
          end
        end
        i2cm_pkg::OP_SACK: begin
          drive_sda(ao, 1'b0);
          drive_scl(1'b1, sda_drv, 8'h00, 1'b0, 1'b0);
          drive_scl(1'b0, sda_drv, 8'h00, 1'b0, 1'b1);
        end
        i2cm_pkg::OP_RACK: begin
          drive_sda(1'b1, 1'b0);
          drive_scl(1'b1, sa, 8'h00, 1'b0, 1'b0);
          drive_scl(1'b0, sa, 8'h00, sa, 1'b1);
        end
        default: begin
        end
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("mismatch after %0d commands: %s", cmds_seen, msg);
      errors++;
    endtask

    task check_phase(pin_phase_t got);
      pin_phase_t exp;
      if (pending_phases.size() == 0) begin
        report_mismatch("output beat with no phase expected");
        return;
      end
      exp = pending_phases.pop_front();
      if (got.scl !== exp.scl)
        report_mismatch($sformatf("scl_level got %b want %b", got.scl, exp.scl));
      if (got.sda !== exp.sda)
        report_mismatch($sformatf("sda_level got %b want %b", got.sda, exp.sda));
      if (got.rbyte !== exp.rbyte)
        report_mismatch($sformatf("read_byte got %h want %h", got.rbyte, exp.rbyte));
      if (got.ack !== exp.ack)
        report_mismatch($sformatf("ack_seen got %b want %b", got.ack, exp.ack));
      if (got.last !== exp.last)
        report_mismatch($sformatf("last_phase got %b want %b", got.last, exp.last));
    endtask
  endclass

  logic       clk        = 1'b0;
  logic       rst        = 1'b1;
  logic       in_valid   = 1'b0;
  logic       in_ready;
  logic [2:0] opcode     = 3'd0;
  logic [7:0] write_data = 8'h00;
  logic       ack_out    = 1'b0;
  logic [7:0] slave_bits = 8'h00;
  logic       slave_ack  = 1'b0;
  logic       out_valid;
  logic       out_ready  = 1'b0;
  logic       scl_level;
  logic       sda_level;
  logic [7:0] read_byte;
  logic       ack_seen;
  logic       last_phase;

  pin_phase_board sb;

  int  cycles     = 0;
  int  burst_left = 0;
  int  items_sent = 0;
  bit  hold_req   = 1'b0;
  bit  hold_taken = 1'b0;
  int  hold_left  = 0;
  int  rx_mode    = 0;
  int  rx_left    = 0;
  int  rx_tick    = 0;

  i2c_master_bit_sequencer uut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .write_data (write_data),
    .ack_out    (ack_out),
    .slave_bits (slave_bits),
    .slave_ack  (slave_ack),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .scl_level  (scl_level),
    .sda_level  (sda_level),
    .read_byte  (read_byte),
    .ack_seen   (ack_seen),
    .last_phase (last_phase)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: checks output beats and stalls on its own pattern
  always @(posedge clk) begin
    pin_phase_t got;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.scl   = scl_level;
        got.sda   = sda_level;
        got.rbyte = read_byte;
        got.ack   = ack_seen;
        got.last  = last_phase;
        sb.check_phase(got);
      end
      rx_tick <= rx_tick + 1;
      if (hold_req && !hold_taken) begin
        hold_taken <= 1'b1;
        hold_left  <= HOLD_CYCLES;
        out_ready  <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        if (rx_left == 0) begin
          rx_mode <= $urandom_range(0, 3);
          rx_left <= $urandom_range(20, 120);
        end else begin
          rx_left <= rx_left - 1;
        end
        case (rx_mode)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= (rx_tick % 5 != 0);
        endcase
      end
    end
  end

  task automatic send_cmd(input logic [2:0] op, input logic [7:0] wd, input logic ao,
                          input logic [7:0] sbits, input logic sa);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    in_valid   <= 1'b1;
    opcode     <= op;
    write_data <= wd;
    ack_out    <= ao;
    slave_bits <= sbits;
    slave_ack  <= sa;
    do @(posedge clk); while (!in_ready);
    sb.note_command(op, wd, ao, sbits, sa);
    burst_left--;
    if (op <= i2cm_pkg::OP_RACK) items_sent++;
  endtask

  task automatic send_op(input logic [2:0] op);
    send_cmd(op, 8'($urandom), 1'($urandom), 8'($urandom), 1'($urandom));
  endtask

  task automatic run_transfer();
    logic [7:0] addr;
    int         nbytes;
    addr   = 8'($urandom);
    nbytes = $urandom_range(0, 3);
    send_op(i2cm_pkg::OP_START);
    send_cmd(i2cm_pkg::OP_WRITE, addr, 1'($urandom), 8'($urandom), 1'($urandom));
    send_cmd(i2cm_pkg::OP_RACK, 8'($urandom), 1'($urandom), 8'($urandom),
             $urandom_range(0, 7) == 0);
    for (int k = 0; k < nbytes; k++) begin
      if (addr[0]) begin
        send_op(i2cm_pkg::OP_READ);
        send_cmd(i2cm_pkg::OP_SACK, 8'($urandom), k == nbytes-1, 8'($urandom),
                 1'($urandom));
      end else begin
        send_op(i2cm_pkg::OP_WRITE);
        send_cmd(i2cm_pkg::OP_RACK, 8'($urandom), 1'($urandom), 8'($urandom),
                 $urandom_range(0, 7) == 0);
      end
    end
    if ($urandom_range(0, 4) == 0) send_op(i2cm_pkg::OP_START);
    send_op(i2cm_pkg::OP_STOP);
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 4)) send_op(3'($urandom_range(0, 7)));
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (sb.pending_phases.size() != 0);
  endtask

  initial begin
    bit paused;
    sb     = new();
    paused = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: byte extremes, every command, repeated start and stop, spare opcodes
    send_op(i2cm_pkg::OP_START);
    send_cmd(i2cm_pkg::OP_WRITE, 8'h00, 1'b1, 8'hFF, 1'b1);
    send_cmd(i2cm_pkg::OP_WRITE, 8'hFF, 1'b0, 8'h00, 1'b0);
    send_cmd(i2cm_pkg::OP_RACK, 8'hFF, 1'b1, 8'hFF, 1'b0);
    send_cmd(i2cm_pkg::OP_WRITE, 8'hA5, 1'b0, 8'h5A, 1'b1);
    send_cmd(i2cm_pkg::OP_RACK, 8'h00, 1'b0, 8'h00, 1'b1);
    send_cmd(i2cm_pkg::OP_READ, 8'hFF, 1'b1, 8'h00, 1'b1);
    send_cmd(i2cm_pkg::OP_SACK, 8'hFF, 1'b0, 8'hFF, 1'b1);
    send_cmd(i2cm_pkg::OP_READ, 8'h00, 1'b0, 8'hFF, 1'b0);
    send_cmd(i2cm_pkg::OP_SACK, 8'h00, 1'b1, 8'h00, 1'b0);
    send_cmd(i2cm_pkg::OP_READ, 8'h3C, 1'b1, 8'h81, 1'b1);
    send_op(i2cm_pkg::OP_RACK);
    send_op(i2cm_pkg::OP_STOP);
    send_op(i2cm_pkg::OP_STOP);
    send_op(i2cm_pkg::OP_START);
    send_op(i2cm_pkg::OP_START);
    send_cmd(OP_SPARE_LO, 8'hFF, 1'b1, 8'hFF, 1'b1);
    send_cmd(OP_SPARE_HI, 8'h00, 1'b0, 8'h00, 1'b0);
    send_cmd(i2cm_pkg::OP_SACK, 8'h5A, 1'b0, 8'hA5, 1'b0);
    send_cmd(i2cm_pkg::OP_WRITE, 8'h5A, 1'b1, 8'hC3, 1'b0);
    send_cmd(i2cm_pkg::OP_RACK, 8'h81, 1'b0, 8'h7E, 1'b0);
    send_cmd(i2cm_pkg::OP_READ, 8'h81, 1'b0, 8'h7E, 1'b1);
    send_op(i2cm_pkg::OP_STOP);

    while (items_sent < TARGET_CMDS) begin
      if (!hold_req && items_sent >= HOLD_AT) hold_req = 1'b1;
      if (!paused && items_sent >= PAUSE_AT) begin
        paused = 1'b1;
        in_valid <= 1'b0;
        burst_left = 0;
        wait_drained();
      end
      if ($urandom_range(0, 9) < 8) run_transfer();
      else send_noise();
    end
    in_valid <= 1'b0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending_phases.size() != 0) sb.report_mismatch("expected phases left over");
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
